/* sv/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Field widths, capacity register defaults, controller states and the
// control group that the controller hands to every cell of the chain.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W           = 32;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;
    localparam int CAP_RESET       = 16;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    // per-cell control: compare against the pending key, or shift one step
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } cell_ctl_t;

endpackage

/* sv/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// A chain of entry cells ordered by recency; each access moves the touched
// entry to the head and ages everything in front of it by one position.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per operation. s_tuser = func (0 get, 1 put),
//   s_tdata = {data_in, key}. m_ channel: one word per operation,
//   m_tuser = {evicted, hit}, m_tdata = {evicted_key, data_out}.
//   cfg_wr_en/cfg_wr_data write capacity_in_use (0 acts as 1, values above
//   ENTRIES act as ENTRIES); write only while the block is idle.
// Operation steps:
//   An accepted word is compared against all cells in the compare state;
//   in the update state the chain shifts and the result is loaded into
//   the output register. The next word is accepted on that same edge, so
//   a new word is not taken before the current one commits; the
//   compare-then-shift of the cell chain sets this.
// Reset: all cells invalid, no entries held, capacity back to 16.
// Stall: the result register holds while m_tready is low; one word may be
//   taken and compared meanwhile, and its update waits for the register.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,     // key[31:0], data_in[63:32]
    input  logic [0:0]                s_tuser,     // func
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,     // data_out[31:0], evicted_key[63:32]
    output logic [1:0]                m_tuser,     // hit[0], evicted[1]
    input  logic                      cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data
);

    localparam int UW   = $clog2(ENTRIES + 1);  // entry count
    localparam int PW   = $clog2(ENTRIES);      // chain position
    localparam int CMPW = (UW > lkvc_pkg::CAP_W) ? UW : lkvc_pkg::CAP_W;
    localparam int KW   = lkvc_pkg::KEY_W;
    localparam int DW   = lkvc_pkg::DATA_W;

    lkvc_pkg::state_t state_reg, state_next;

    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [UW-1:0]              used_reg;

    // pending operation
    logic          op_func_reg;
    logic [KW-1:0] op_key_reg;
    logic [DW-1:0] op_data_reg;

    // output register
    logic          m_tvalid_reg;
    logic          hit_out_reg;
    logic          evicted_out_reg;
    logic [DW-1:0] data_out_reg;
    logic [KW-1:0] evicted_key_reg;

    // chain wiring: index 0 is the head feed, cell i sits between i and i+1
    logic [KW-1:0] chain_key   [ENTRIES+1];
    logic [DW-1:0] chain_value [ENTRIES+1];
    logic          chain_valid [ENTRIES+1];

    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    valid_vec;
    logic [DW-1:0]         hit_value_arr [ENTRIES];
    logic [KW-1:0]         tail_key_arr  [ENTRIES];
    lkvc_pkg::cell_ctl_t   cell_ctl      [ENTRIES];

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic                 hit;
    logic                 do_update;
    logic                 fresh;
    logic                 evict;
    logic [PW-1:0]        hit_pos;
    logic [PW-1:0]        shift_lim;
    logic [DW-1:0]        hit_value;
    logic [KW-1:0]        tail_key;
    logic [lkvc_pkg::CAP_W-1:0] cap_min1;

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == lkvc_pkg::ST_UPD) && out_free;
    assign s_tready = (state_reg == lkvc_pkg::ST_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;

    // ---- reductions over the registered compare results ----
    always_comb begin
        hit_pos   = '0;
        hit_value = '0;
        tail_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                hit_pos = hit_pos | PW'(i);
            end
            hit_value = hit_value | hit_value_arr[i];
            tail_key  = tail_key | tail_key_arr[i];
        end
    end

    assign hit       = |match_vec;
    assign cap_min1  = (cap_reg == '0) ? lkvc_pkg::CAP_W'(1) : cap_reg;
    assign fresh     = (used_reg < UW'(ENTRIES)) && (CMPW'(used_reg) < CMPW'(cap_min1));
    assign evict     = (op_func_reg == lkvc_pkg::FUNC_PUT) && !hit && !fresh;
    assign do_update = (op_func_reg == lkvc_pkg::FUNC_PUT) || hit;

    // Hit: positions 0..hit_pos rotate. Fresh insert: 0..used shift in the
    // new entry. Eviction: 0..used-1 shift and the tail entry falls off.
    always_comb begin
        if (hit) begin
            shift_lim = hit_pos;
        end else if (fresh) begin
            shift_lim = PW'(used_reg);
        end else begin
            shift_lim = PW'(used_reg - UW'(1));
        end
    end

    // head feed
    assign chain_key[0]   = op_key_reg;
    assign chain_value[0] = (hit && op_func_reg == lkvc_pkg::FUNC_GET) ? hit_value : op_data_reg;
    assign chain_valid[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic nv;
            // valid bit of the next cell down the chain
            if (g == ENTRIES - 1) begin : g_last
                assign nv = 1'b0;
            end else begin : g_mid
                assign nv = chain_valid[g+2];
            end

            assign cell_ctl[g].cmp_en   = (state_reg == lkvc_pkg::ST_CMP);
            assign cell_ctl[g].shift_en = commit && do_update && (PW'(g) <= shift_lim);

            lkvc_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (cell_ctl[g]),
                .prev_key    (chain_key[g]),
                .prev_value  (chain_value[g]),
                .prev_valid  (chain_valid[g]),
                .next_valid  (nv),
                .op_key      (op_key_reg),
                .key_o       (chain_key[g+1]),
                .value_o     (chain_value[g+1]),
                .valid_o     (chain_valid[g+1]),
                .match_o     (match_vec[g]),
                .hit_value_o (hit_value_arr[g]),
                .tail_key_o  (tail_key_arr[g])
            );

            assign valid_vec[g] = chain_valid[g+1];
        end
    endgenerate

    // ---- controller ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lkvc_pkg::ST_IDLE: begin
                if (accept) state_next = lkvc_pkg::ST_CMP;
            end
            lkvc_pkg::ST_CMP: begin
                state_next = lkvc_pkg::ST_UPD;
            end
            lkvc_pkg::ST_UPD: begin
                if (commit) state_next = accept ? lkvc_pkg::ST_CMP : lkvc_pkg::ST_IDLE;
            end
            default: begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lkvc_pkg::ST_IDLE;
            cap_reg      <= lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (commit && (op_func_reg == lkvc_pkg::FUNC_PUT) && !hit && fresh) begin
                used_reg <= used_reg + UW'(1);
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_func_reg <= s_tuser[0];
            op_key_reg  <= s_tdata[31:0];
            op_data_reg <= s_tdata[63:32];
        end
        if (commit) begin
            hit_out_reg     <= hit;
            data_out_reg    <= (hit && op_func_reg == lkvc_pkg::FUNC_GET) ? hit_value : '0;
            evicted_out_reg <= evict;
            evicted_key_reg <= evict ? tail_key : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {evicted_key_reg, data_out_reg};
    assign m_tuser  = {evicted_out_reg, hit_out_reg};

    // ---- assertions ----
    // the count of valid cells always equals the entry count
    a_used_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(used_reg))
        else $error("entry count disagrees with valid cells");

    // a key is held at most once
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lkvc_pkg::ST_UPD) |-> $onehot0(match_vec))
        else $error("key matched in more than one cell");

    // a new result only comes from the update step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == lkvc_pkg::ST_UPD))
        else $error("result raised outside the update step");

    // eviction leaves the entry count unchanged; it only happens with a full chain or capacity reached
    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && evict) |=> $stable(used_reg))
        else $error("entry count changed on eviction");

endmodule

/* sv/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the recency chain
// Holds a key, a value and a valid bit. Position in the chain is the
// recency rank. On shift it takes its upstream neighbor's entry; on
// compare it registers its match, its value if matched, and its key if
// it is the last valid cell (the least recently used one).
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lkvc_pkg::cell_ctl_t        ctl,
    input  logic [lkvc_pkg::KEY_W-1:0]  prev_key,
    input  logic [lkvc_pkg::DATA_W-1:0] prev_value,
    input  logic                       prev_valid,
    input  logic                       next_valid,
    input  logic [lkvc_pkg::KEY_W-1:0]  op_key,
    output logic [lkvc_pkg::KEY_W-1:0]  key_o,
    output logic [lkvc_pkg::DATA_W-1:0] value_o,
    output logic                       valid_o,
    output logic                       match_o,
    output logic [lkvc_pkg::DATA_W-1:0] hit_value_o,
    output logic [lkvc_pkg::KEY_W-1:0]  tail_key_o
);

    logic [lkvc_pkg::KEY_W-1:0]  key_reg;
    logic [lkvc_pkg::DATA_W-1:0] value_reg;
    logic                        valid_reg;
    logic                        match_reg;
    logic                        match_next;
    logic [lkvc_pkg::DATA_W-1:0] hit_value_reg;
    logic [lkvc_pkg::KEY_W-1:0]  tail_key_reg;

    assign match_next = valid_reg && (key_reg == op_key);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctl.shift_en) begin
                valid_reg <= prev_valid;
            end
            if (ctl.cmp_en) begin
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift_en) begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
        if (ctl.cmp_en) begin
            hit_value_reg <= match_next ? value_reg : '0;
            tail_key_reg  <= (valid_reg && !next_valid) ? key_reg : '0;
        end
    end

    assign key_o       = key_reg;
    assign value_o     = value_reg;
    assign valid_o     = valid_reg;
    assign match_o     = match_reg;
    assign hit_value_o = hit_value_reg;
    assign tail_key_o  = tail_key_reg;

endmodule

/* tb/tb_lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache: self-checking bench for the LRU key-value cache
// Drives get/put words through the input stream, predicts every result word
// with an independent LRU model and compares it field by field. Runs a
// directed opening, then random phases under several capacity settings,
// with bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

    localparam int SLOTS      = lkvc_pkg::ENTRIES_DEFAULT;
    localparam int POOL_MAX   = 24;
    localparam int PHASE_OPS  = 186;
    localparam int LONG_HOLD  = 300;       // cycles of held-off m_tready
    localparam int HOLD_AFTER = 400;       // result count that triggers it
    localparam int CYCLE_LIMIT = 400000;

    // ------------------------------------------------------------------
    // Scoreboard: LRU predictor plus queue of expected result words
    // ------------------------------------------------------------------
    class cache_scoreboard;
        typedef struct {
            bit                        hit;
            bit [lkvc_pkg::DATA_W-1:0] data_out;
            bit                        evicted;
            bit [lkvc_pkg::KEY_W-1:0]  evicted_key;
        } lookup_t;

        bit [lkvc_pkg::KEY_W-1:0]  slot_key [SLOTS];
        bit [lkvc_pkg::DATA_W-1:0] slot_val [SLOTS];
        bit                        slot_live [SLOTS];
        int unsigned               slot_age [SLOTS];    // 0 = most recent
        int unsigned               live_count;
        bit [lkvc_pkg::CAP_W-1:0]  capacity = lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);

        lookup_t outcome_q [$];
        int failures;
        int checked;
        int gets, puts, hits, evictions;

        function void set_capacity(bit [lkvc_pkg::CAP_W-1:0] v);
            capacity = v;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // touched slot goes to the front; anything newer than it ages by one
        function void promote(int s, int unsigned old_age);
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i] && i != s && slot_age[i] < old_age)
                    slot_age[i]++;
            slot_age[s] = 0;
        endfunction

        function void note_request(bit func, bit [lkvc_pkg::KEY_W-1:0] key,
                                   bit [lkvc_pkg::DATA_W-1:0] data);
            lookup_t r;
            int found;
            int slot;
            int unsigned limit;
            int unsigned worst;
            r = '{default: 0};
            found = -1;
            slot = -1;
            worst = 0;
            limit = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
            if (func == lkvc_pkg::FUNC_PUT) puts++; else gets++;

            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && slot_live[i] && slot_key[i] == key)
                    found = i;

            if (found >= 0) begin
                r.hit = 1'b1;
                if (func == lkvc_pkg::FUNC_GET)
                    r.data_out = slot_val[found];
                else
                    slot_val[found] = data;
                promote(found, slot_age[found]);
            end else if (func == lkvc_pkg::FUNC_PUT) begin
                if (live_count < limit)
                    for (int i = 0; i < SLOTS; i++)
                        if (slot < 0 && !slot_live[i])
                            slot = i;
                if (slot >= 0) begin
                    // free slot: everything held ages by one
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i])
                            slot_age[i]++;
                    slot_live[slot] = 1'b1;
                    live_count++;
                end else begin
                    // replace the oldest entry; last one wins on a tie
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i] && (slot < 0 || slot_age[i] >= worst)) begin
                            slot = i;
                            worst = slot_age[i];
                        end
                    r.evicted = 1'b1;
                    r.evicted_key = slot_key[slot];
                    promote(slot, worst);
                end
                slot_key[slot] = key;
                slot_val[slot] = data;
                slot_age[slot] = 0;
            end
            if (r.hit) hits++;
            if (r.evicted) evictions++;
            outcome_q.push_back(r);
        endfunction

        function void check_response(bit hit, bit [lkvc_pkg::DATA_W-1:0] data_out,
                                     bit evicted, bit [lkvc_pkg::KEY_W-1:0] evicted_key);
            lookup_t e;
            checked++;
            if (outcome_q.size() == 0) begin
                $display("%0t: result word with nothing expected (hit %0b data %h)",
                         $time, hit, data_out);
                failures++;
                return;
            end
            e = outcome_q.pop_front();
            if (hit !== e.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                failures++;
            end
            if (data_out !== e.data_out) begin
                $display("%0t: data_out expected %h actual %h", $time, e.data_out, data_out);
                failures++;
            end
            if (evicted !== e.evicted) begin
                $display("%0t: evicted expected %0b actual %0b", $time, e.evicted, evicted);
                failures++;
            end
            if (evicted_key !== e.evicted_key) begin
                $display("%0t: evicted_key expected %h actual %h",
                         $time, e.evicted_key, evicted_key);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                       aclk;
    logic                       aresetn     = 1'b0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [63:0]                s_tdata     = '0;    // key[31:0], data_in[63:32]
    logic [0:0]                 s_tuser     = '0;    // func
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [63:0]                m_tdata;             // data_out[31:0], evicted_key[63:32]
    logic [1:0]                 m_tuser;             // hit[0], evicted[1]
    logic                       cfg_wr_en   = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data = '0;

    cache_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int settings_used = 1;                 // reset value counts as one
    bit [lkvc_pkg::KEY_W-1:0] key_pool [POOL_MAX];
    int pool_size;

    lru_key_value_cache DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: the run must not outlive the cycle budget
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, sb.pending());
        $display("[lru_key_value_cache] ERROR");
        $finish;
    end

    // Input monitor: every accepted word goes into the predictor.
    // Reads at posedge see the pre-edge values, so no race with the DUT.
    always @(posedge aclk)
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);

    // Output monitor
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_response(m_tuser[0], m_tdata[31:0], m_tuser[1], m_tdata[63:32]);

    // ------------------------------------------------------------------
    // Result sink: random ready/stall runs, some long calm stretches,
    // and one long hold-off so the cache backs up into s_tready.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int  run_left;
        bit  ready_now;
        bit  hold_done;
        run_left = 0;
        ready_now = 1'b0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && sb.checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                run_left = 0;
                ready_now = 1'b0;
            end else begin
                if (run_left == 0) begin
                    ready_now = !ready_now;
                    if (ready_now)
                        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                               : $urandom_range(1, 8);
                    else
                        run_left = $urandom_range(1, 5);
                end
                run_left--;
                m_tready <= ready_now;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------
    // present one word and hold it until the cache takes it
    task automatic send_word(bit func, bit [lkvc_pkg::KEY_W-1:0] key,
                             bit [lkvc_pkg::DATA_W-1:0] data);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {data, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic go_quiet(int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (extra) @(negedge aclk);
    endtask

    // all results in, then an idle margin before touching the register
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(bit [lkvc_pkg::CAP_W-1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.set_capacity(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // fresh key pool, a few keys wider than the usable capacity
    task automatic refill_pool(bit [lkvc_pkg::CAP_W-1:0] cap);
        int usable;
        usable = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap;
        pool_size = usable + $urandom_range(1, 6);
        for (int i = 0; i < POOL_MAX; i++)
            case ($urandom_range(0, 15))
                0:       key_pool[i] = '0;
                1:       key_pool[i] = '1;
                default: key_pool[i] = $urandom;
            endcase
    endtask

    // mostly pool keys (hits, updates, evictions), some stray random keys
    task automatic random_phase(int ops);
        int left;
        int burst;
        int gap;
        bit [lkvc_pkg::KEY_W-1:0] k;
        left = ops;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) burst = left;
            repeat (burst) begin
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    k = $urandom;
                send_word($urandom_range(0, 1) ? lkvc_pkg::FUNC_PUT : lkvc_pkg::FUNC_GET,
                          k, $urandom);
            end
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) go_quiet(gap - 1);
        end
        go_quiet(0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit [lkvc_pkg::CAP_W-1:0] phase_caps [9] = '{31, 3, 1, 16, 0, 8, 17, 2, 16};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty miss, key/data extremes, put hit, fill, evict
        send_word(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(lkvc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
        send_word(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        for (int k = 1; k <= 14; k++)
            send_word(lkvc_pkg::FUNC_PUT, k, ~k);
        // table now full: next miss put pushes out the oldest entry
        send_word(lkvc_pkg::FUNC_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_word(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        go_quiet(0);

        // capacity zero acts as one, and it is far below the entries held
        write_capacity(0);
        send_word(lkvc_pkg::FUNC_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_word(lkvc_pkg::FUNC_GET, 32'hA5A5_A5A5, 32'h0000_0000);
        go_quiet(0);

        // random phases under a spread of capacity settings
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            refill_pool(phase_caps[p]);
            random_phase(PHASE_OPS);
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("covered %0d gets and %0d puts (%0d hits, %0d evictions) over %0d capacities",
                 sb.gets, sb.puts, sb.hits, sb.evictions, settings_used);
        $display("%0d result words checked, %0d mismatches", sb.checked, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[lru_key_value_cache] OK");
        else
            $display("[lru_key_value_cache] ERROR");
        $finish;
    end

endmodule
